[hdl/l1ap_pkg.sv]
// shared types, constants and saturation helper for the l1 adaptive predictor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package l1ap_pkg;

    localparam int AXES_DEF      = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int AXIS_W        = 2;

    localparam logic [16:0] STEP_TIME_RST      = 17'd655;
    localparam logic [30:0] PREDICTOR_POLE_RST = 31'd655360;
    localparam logic [31:0] INPUT_GAIN_RST     = 32'd65536;
    localparam logic [30:0] SIGMA_LIMIT_RST    = 31'd1310720;
    localparam logic [16:0] FILTER_ALPHA_RST   = 17'd58982;

    localparam logic [2:0] REG_STEP_TIME      = 3'd0;
    localparam logic [2:0] REG_PREDICTOR_POLE = 3'd1;
    localparam logic [2:0] REG_INPUT_GAIN     = 3'd2;
    localparam logic [2:0] REG_SIGMA_LIMIT    = 3'd3;
    localparam logic [2:0] REG_FILTER_ALPHA   = 3'd4;

    typedef enum logic [4:0] {
        S_E   = 5'd0,
        S_M1  = 5'd1,
        S_R1  = 5'd2,
        S_M2  = 5'd3,
        S_PP  = 5'd4,
        S_M3  = 5'd5,
        S_A3  = 5'd6,
        S_M4  = 5'd7,
        S_R2  = 5'd8,
        S_M5  = 5'd9,
        S_PV  = 5'd10,
        S_VE  = 5'd11,
        S_M6  = 5'd12,
        S_A6  = 5'd13,
        S_M7  = 5'd14,
        S_SG  = 5'd15,
        S_M8  = 5'd16,
        S_A8  = 5'd17,
        S_M9  = 5'd18,
        S_CP  = 5'd19
    } t_step;

    typedef struct packed {
        logic              capture;
        logic              seed;
        logic              p2_mul;
        logic              p2_wr;
        logic              run;
        logic              load_out;
        t_step             step;
        logic [AXIS_W-1:0] axis;
    } t_cmd;

    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/l1ap_ctrl.sv]
// controller state machine: input/output handshake and micro-step sequencing
// depends on l1ap_pkg
`timescale 1ns / 1ps
`default_nettype none
module l1ap_ctrl import l1ap_pkg::*; #(
    parameter int AXES = AXES_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  wire  i_op,
    output logic o_in_stall,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SEED = 6'b000010,
        ST_P2M  = 6'b000100,
        ST_P2W  = 6'b001000,
        ST_RUN  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    t_state            r_state, n_state;
    t_step             r_step, n_step;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic              r_out_valid, n_out_valid;
    logic              w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        o_cmd.axis  = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_op ? ST_SEED : ST_P2M;
                end
            end
            ST_SEED: begin
                o_cmd.seed = 1'b1;
                n_state = ST_OUT;
            end
            ST_P2M: begin
                o_cmd.p2_mul = 1'b1;
                n_state = ST_P2W;
            end
            ST_P2W: begin
                o_cmd.p2_wr = 1'b1;
                n_step  = S_E;
                n_axis  = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                o_cmd.run = 1'b1;
                if (r_step == S_CP) begin
                    n_step = S_E;
                    if (r_axis == LAST_AXIS) begin
                        n_state = ST_OUT;
                    end else begin
                        n_axis = r_axis + 1'b1;
                    end
                end else begin
                    n_step = t_step'(r_step + 5'd1);
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= S_E;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

[hdl/l1ap_dp.sv]
// datapath: predictor state, one shared multiplier, rounding and saturation
// depends on l1ap_pkg
`timescale 1ns / 1ps
`default_nettype none
module l1ap_dp import l1ap_pkg::*; #(
    parameter int AXES      = AXES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    input  wire signed  [31:0] i_meas [3],
    input  wire signed  [31:0] i_vel [3],
    input  wire signed  [31:0] i_acc [3],
    input  wire         [16:0] i_step_time,
    input  wire         [30:0] i_pole,
    input  wire signed  [31:0] i_gain,
    input  wire         [30:0] i_limit,
    input  wire         [16:0] i_alpha,
    output logic signed [31:0] o_comp [3],
    output logic signed [31:0] o_sigma [3],
    output logic signed [31:0] o_err [3]
);

    localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic signed [65:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [32:0] ONE   = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] MAX66 = 66'sd2147483647;
    localparam logic signed [65:0] MIN66 = -66'sd2147483648;

    logic signed [31:0] r_meas [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_acc [3];
    logic signed [31:0] r_pp [AXES];
    logic signed [31:0] r_pv [AXES];
    logic signed [31:0] r_sg [AXES];
    logic signed [31:0] r_cp [AXES];
    logic signed [31:0] r_er [AXES];
    logic signed [31:0] r_e, r_t, r_p2;
    logic signed [65:0] r_prod;
    logic signed [31:0] r_o_comp [3];
    logic signed [31:0] r_o_sigma [3];
    logic signed [31:0] r_o_err [3];

    logic [AXW-1:0]     w_ax;
    logic signed [31:0] w_meas, w_vel, w_acc, w_pp, w_pv, w_sg, w_cp, w_er;
    logic signed [65:0] w_sh;
    logic signed [31:0] w_rnd;
    logic signed [32:0] w_ma, w_mb;
    logic               w_mul;
    logic signed [31:0] w_two, w_sgs;
    logic signed [35:0] w_lim;

    assign w_ax   = i_cmd.axis[AXW-1:0];
    assign w_meas = r_meas[w_ax];
    assign w_vel  = r_vel[w_ax];
    assign w_acc  = r_acc[w_ax];
    assign w_pp   = r_pp[w_ax];
    assign w_pv   = r_pv[w_ax];
    assign w_sg   = r_sg[w_ax];
    assign w_cp   = r_cp[w_ax];
    assign w_er   = r_er[w_ax];

    // round half up then saturate
    assign w_sh  = (r_prod + HALF) >>> FRAC_BITS;
    assign w_rnd = (w_sh > MAX66) ? 32'sh7fffffff :
                   (w_sh < MIN66) ? 32'sh80000000 : w_sh[31:0];

    assign w_two = sat36(36'(w_rnd) + 36'(w_rnd));
    assign w_sgs = sat36(-36'(r_t) - 36'(w_rnd));
    assign w_lim = 36'({5'b0, i_limit});

    always_comb begin
        w_mul = 1'b1;
        w_ma  = 33'(r_t);
        w_mb  = 33'({16'b0, i_step_time});
        if (i_cmd.p2_mul) begin
            w_ma = 33'({2'b0, i_pole});
            w_mb = 33'({2'b0, i_pole});
        end else if (i_cmd.run) begin
            case (i_cmd.step)
                S_M1: begin
                    w_ma = 33'({2'b0, i_pole});
                    w_mb = 33'(r_e);
                end
                S_M2, S_M5: begin
                    w_ma = 33'(r_t);
                    w_mb = 33'({16'b0, i_step_time});
                end
                S_M3: begin
                    w_ma = 33'(i_gain);
                    w_mb = 33'(w_acc);
                end
                S_M4: begin
                    w_ma = 33'(r_p2);
                    w_mb = 33'(r_e);
                end
                S_M6: begin
                    w_ma = 33'({2'b0, i_pole});
                    w_mb = 33'(r_t);
                end
                S_M7: begin
                    w_ma = 33'(r_p2);
                    w_mb = 33'(w_er);
                end
                S_M8: begin
                    w_ma = 33'({16'b0, i_alpha});
                    w_mb = 33'(w_cp);
                end
                S_M9: begin
                    w_ma = ONE - 33'({16'b0, i_alpha});
                    w_mb = -33'(w_sg);
                end
                default: w_mul = 1'b0;
            endcase
        end else begin
            w_mul = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_meas <= i_meas;
            r_vel  <= i_vel;
            r_acc  <= i_acc;
        end
        if (w_mul) begin
            r_prod <= w_ma * w_mb;
        end
        if (i_cmd.p2_wr) begin
            r_p2 <= w_rnd;
        end
        if (i_cmd.run) begin
            case (i_cmd.step)
                S_E:  r_e <= sat36(36'(w_meas) - 36'(w_pp));
                S_R1: r_t <= sat36(36'(w_pv) + 36'(w_two));
                S_A3, S_A6, S_A8: r_t <= w_rnd;
                S_R2: r_t <= sat36(36'(w_sg) + 36'(r_t) + 36'(w_rnd));
                S_VE: r_t <= sat36(36'(w_pv) - 36'(w_vel));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_pp[a] <= '0;
                r_pv[a] <= '0;
                r_sg[a] <= '0;
                r_cp[a] <= '0;
                r_er[a] <= '0;
            end
        end else if (i_cmd.seed) begin
            for (int a = 0; a < AXES; a++) begin
                r_pp[a] <= r_meas[a];
                r_pv[a] <= r_vel[a];
                r_sg[a] <= '0;
                r_cp[a] <= '0;
                r_er[a] <= '0;
            end
        end else if (i_cmd.run) begin
            case (i_cmd.step)
                S_PP: r_pp[w_ax] <= sat36(36'(w_pp) + 36'(w_rnd));
                S_PV: begin
                    r_pv[w_ax] <= sat36(36'(w_pv) + 36'(w_rnd));
                    r_er[w_ax] <= sat36(36'(w_pp) - 36'(w_meas));
                end
                S_SG: begin
                    if (36'(w_sgs) > w_lim) begin
                        r_sg[w_ax] <= 32'(w_lim);
                    end else if (36'(w_sgs) < -w_lim) begin
                        r_sg[w_ax] <= 32'(-w_lim);
                    end else begin
                        r_sg[w_ax] <= w_sgs;
                    end
                end
                S_CP: r_cp[w_ax] <= sat36(36'(r_t) + 36'(w_rnd));
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_out
        if (g < AXES) begin : g_used
            always_ff @(posedge i_clk) begin
                if (i_cmd.load_out) begin
                    r_o_comp[g]  <= r_cp[g];
                    r_o_sigma[g] <= r_sg[g];
                    r_o_err[g]   <= r_er[g];
                end
            end
        end else begin : g_unused
            always_ff @(posedge i_clk) begin
                r_o_comp[g]  <= '0;
                r_o_sigma[g] <= '0;
                r_o_err[g]   <= '0;
            end
        end
        assign o_comp[g]  = r_o_comp[g];
        assign o_sigma[g] = r_o_sigma[g];
        assign o_err[g]   = r_o_err[g];
    end

endmodule
`default_nettype wire

[hdl/l1_adaptive_predictor_3axis_unit.sv]
// Three-axis L1 adaptive state predictor and disturbance compensator, Q16.16.
// Input channel: i_in_valid / o_in_stall with op, measured, velocity and
// commanded acceleration per axis; output channel: o_out_valid / i_out_stall
// with compensation, clipped sigma and prediction error per axis.
// A transfer on either channel happens when valid is high and stall is low.
// One item is worked at a time through a single shared 33x33 multiplier:
// an update runs the micro-step sequence once per axis, a seed item only
// loads the state; the input is stalled meanwhile.
// The result sits in an output register; the next item is accepted as soon
// as the result is loaded, even while the receiver stalls it. While the
// receiver stalls, the next result waits in the datapath until the output
// register is free.
// Synchronous active-low reset clears predictor state, sigma, compensation
// and loads register defaults. APB-style config at byte address 4*index;
// the user writes it only while idle (the block does not enforce this).
// pready is always high. Depends on l1ap_pkg, l1ap_ctrl, l1ap_dp.
`timescale 1ns / 1ps
`default_nettype none
module l1_adaptive_predictor_3axis_unit import l1ap_pkg::*; #(
    parameter int AXES      = AXES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire         [4:0]  paddr,
    input  wire         [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire                i_op,
    input  wire signed  [31:0] i_measured_x,
    input  wire signed  [31:0] i_measured_y,
    input  wire signed  [31:0] i_measured_z,
    input  wire signed  [31:0] i_velocity_x,
    input  wire signed  [31:0] i_velocity_y,
    input  wire signed  [31:0] i_velocity_z,
    input  wire signed  [31:0] i_accel_cmd_x,
    input  wire signed  [31:0] i_accel_cmd_y,
    input  wire signed  [31:0] i_accel_cmd_z,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [31:0] o_comp_x,
    output logic signed [31:0] o_comp_y,
    output logic signed [31:0] o_comp_z,
    output logic signed [31:0] o_sigma_x,
    output logic signed [31:0] o_sigma_y,
    output logic signed [31:0] o_sigma_z,
    output logic signed [31:0] o_pred_err_x,
    output logic signed [31:0] o_pred_err_y,
    output logic signed [31:0] o_pred_err_z
);

    logic [16:0]        r_step_time;
    logic [30:0]        r_pole;
    logic signed [31:0] r_gain;
    logic [30:0]        r_limit;
    logic [16:0]        r_alpha;
    logic [2:0]         w_idx;
    t_cmd               w_cmd;
    logic signed [31:0] w_meas [3];
    logic signed [31:0] w_vel [3];
    logic signed [31:0] w_acc [3];
    logic signed [31:0] w_comp [3];
    logic signed [31:0] w_sigma [3];
    logic signed [31:0] w_err [3];

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_TIME_RST;
            r_pole      <= PREDICTOR_POLE_RST;
            r_gain      <= INPUT_GAIN_RST;
            r_limit     <= SIGMA_LIMIT_RST;
            r_alpha     <= FILTER_ALPHA_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_STEP_TIME:      r_step_time <= pwdata[16:0];
                REG_PREDICTOR_POLE: r_pole      <= pwdata[30:0];
                REG_INPUT_GAIN:     r_gain      <= pwdata;
                REG_SIGMA_LIMIT:    r_limit     <= pwdata[30:0];
                REG_FILTER_ALPHA:   r_alpha     <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_STEP_TIME:      prdata = {15'b0, r_step_time};
            REG_PREDICTOR_POLE: prdata = {1'b0, r_pole};
            REG_INPUT_GAIN:     prdata = r_gain;
            REG_SIGMA_LIMIT:    prdata = {1'b0, r_limit};
            REG_FILTER_ALPHA:   prdata = {15'b0, r_alpha};
            default:            prdata = '0;
        endcase
    end

    assign w_meas[0] = i_measured_x;
    assign w_meas[1] = i_measured_y;
    assign w_meas[2] = i_measured_z;
    assign w_vel[0]  = i_velocity_x;
    assign w_vel[1]  = i_velocity_y;
    assign w_vel[2]  = i_velocity_z;
    assign w_acc[0]  = i_accel_cmd_x;
    assign w_acc[1]  = i_accel_cmd_y;
    assign w_acc[2]  = i_accel_cmd_z;

    l1ap_ctrl #(
        .AXES (AXES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    l1ap_dp #(
        .AXES      (AXES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_meas      (w_meas),
        .i_vel       (w_vel),
        .i_acc       (w_acc),
        .i_step_time (r_step_time),
        .i_pole      (r_pole),
        .i_gain      (r_gain),
        .i_limit     (r_limit),
        .i_alpha     (r_alpha),
        .o_comp      (w_comp),
        .o_sigma     (w_sigma),
        .o_err       (w_err)
    );

    assign o_comp_x     = w_comp[0];
    assign o_comp_y     = w_comp[1];
    assign o_comp_z     = w_comp[2];
    assign o_sigma_x    = w_sigma[0];
    assign o_sigma_y    = w_sigma[1];
    assign o_sigma_z    = w_sigma[2];
    assign o_pred_err_x = w_err[0];
    assign o_pred_err_y = w_err[1];
    assign o_pred_err_z = w_err[2];

endmodule
`default_nettype wire

[test/l1ap_checker.sv]
// checker for the three-axis l1 adaptive predictor: watches both channels,
// predicts each result in q16.16 and compares field by field
// depends on l1ap_pkg for register indexes
`timescale 1ns / 1ps
module l1ap_checker import l1ap_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire        [4:0]  paddr,
    input  wire        [31:0] pwdata,
    input  wire               i_in_valid,
    input  wire               o_in_stall,
    input  wire               i_op,
    input  wire signed [31:0] i_meas [3],
    input  wire signed [31:0] i_vel [3],
    input  wire signed [31:0] i_acc [3],
    input  wire               o_out_valid,
    input  wire               i_out_stall,
    input  wire signed [31:0] o_comp [3],
    input  wire signed [31:0] o_sigma [3],
    input  wire signed [31:0] o_err [3],
    output int                fail_count,
    output int                pending
);
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] comp [3];
        logic signed [31:0] sigma [3];
        logic signed [31:0] err [3];
    } t_result;

    t_result result_q [$];
    longint pos_s [3];
    longint vel_s [3];
    longint sig_s [3];
    longint cmp_s [3];
    longint dt, pole, gain, lim, alpha;

    function automatic longint clip32(longint v);
        if (v > MAXV) return MAXV;
        if (v < MINV) return MINV;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + 64'sd32768;
        return clip32(p >>> 16);
    endfunction

    task automatic advance_axes(input logic seed, output t_result r);
        longint p2, e, rate, er, ve, sg;
        p2 = qmul(pole, pole);
        for (int a = 0; a < 3; a++) begin
            if (seed) begin
                pos_s[a] = i_meas[a];
                vel_s[a] = i_vel[a];
                sig_s[a] = 0;
                cmp_s[a] = 0;
                r.comp[a] = 0;
                r.sigma[a] = 0;
                r.err[a] = 0;
            end else begin
                e = clip32(i_meas[a] - pos_s[a]);
                rate = clip32(vel_s[a] + clip32(2 * qmul(pole, e)));
                pos_s[a] = clip32(pos_s[a] + qmul(rate, dt));
                rate = clip32(sig_s[a] + qmul(gain, i_acc[a]) + qmul(p2, e));
                vel_s[a] = clip32(vel_s[a] + qmul(rate, dt));
                er = clip32(pos_s[a] - i_meas[a]);
                ve = clip32(vel_s[a] - i_vel[a]);
                sg = clip32(-qmul(pole, ve) - qmul(p2, er));
                if (sg > lim) sg = lim;
                if (sg < -lim) sg = -lim;
                sig_s[a] = sg;
                cmp_s[a] = clip32(qmul(alpha, cmp_s[a]) + qmul(65536 - alpha, -sg));
                r.comp[a] = cmp_s[a][31:0];
                r.sigma[a] = sg[31:0];
                r.err[a] = er[31:0];
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result r, x;
        int n_err;
        n_err = 0;
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                pos_s[a] = 0;
                vel_s[a] = 0;
                sig_s[a] = 0;
                cmp_s[a] = 0;
            end
            dt = 655;
            pole = 655360;
            gain = 65536;
            lim = 1310720;
            alpha = 58982;
            result_q.delete();
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    REG_STEP_TIME:      dt = pwdata[16:0];
                    REG_PREDICTOR_POLE: pole = pwdata[30:0];
                    REG_INPUT_GAIN:     gain = longint'($signed(pwdata));
                    REG_SIGMA_LIMIT:    lim = pwdata[30:0];
                    REG_FILTER_ALPHA:   alpha = pwdata[16:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    n_err++;
                end else begin
                    x = result_q.pop_front();
                    for (int a = 0; a < 3; a++) begin
                        if (o_comp[a] !== x.comp[a]) begin
                            $error("comp[%0d] expected %0d actual %0d", a, x.comp[a], o_comp[a]);
                            n_err++;
                        end
                        if (o_sigma[a] !== x.sigma[a]) begin
                            $error("sigma[%0d] expected %0d actual %0d", a, x.sigma[a],
                                o_sigma[a]);
                            n_err++;
                        end
                        if (o_err[a] !== x.err[a]) begin
                            $error("pred_err[%0d] expected %0d actual %0d", a, x.err[a],
                                o_err[a]);
                            n_err++;
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                advance_axes(i_op, r);
                result_q.push_back(r);
            end
            if (n_err != 0) fail_count <= fail_count + n_err;
        end
        pending <= result_q.size();
    end
endmodule

[test/testbench.sv]
// stimulus and verdict for the three-axis l1 adaptive predictor
// depends on l1ap_pkg, the unit under test and l1ap_checker
`timescale 1ns / 1ps
module testbench;
    import l1ap_pkg::*;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic i_in_valid, o_in_stall, i_op;
    logic signed [31:0] meas [3];
    logic signed [31:0] vel [3];
    logic signed [31:0] acc [3];
    logic o_out_valid, i_out_stall;
    logic signed [31:0] comp [3];
    logic signed [31:0] sigma [3];
    logic signed [31:0] perr [3];
    int fail_count, pending;
    int idle_cycles;
    bit hold_long;
    bit done_stim;

    l1_adaptive_predictor_3axis_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_op(i_op),
        .i_measured_x(meas[0]), .i_measured_y(meas[1]), .i_measured_z(meas[2]),
        .i_velocity_x(vel[0]), .i_velocity_y(vel[1]), .i_velocity_z(vel[2]),
        .i_accel_cmd_x(acc[0]), .i_accel_cmd_y(acc[1]), .i_accel_cmd_z(acc[2]),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_comp_x(comp[0]), .o_comp_y(comp[1]), .o_comp_z(comp[2]),
        .o_sigma_x(sigma[0]), .o_sigma_y(sigma[1]), .o_sigma_z(sigma[2]),
        .o_pred_err_x(perr[0]), .o_pred_err_y(perr[1]), .o_pred_err_z(perr[2])
    );

    l1ap_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_op(i_op), .i_meas(meas), .i_vel(vel), .i_acc(acc),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_comp(comp), .o_sigma(sigma), .o_err(perr),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'd0 : 32'hffffffff;
            3: return $urandom;
            default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0 || (i_in_valid && o_in_stall)) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic send(input logic op, input logic [31:0] m, input bit gap);
        int wait_n;
        wait_n = gap ? $urandom_range(0, 18) : 0;
        if ($urandom_range(0, 3) == 0) wait_n = 0;
        if (wait_n != 0) begin
            i_in_valid <= 0;
            repeat (wait_n) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_op <= op;
        for (int a = 0; a < 3; a++) begin
            meas[a] <= (m == 0) ? rand_q() : m;
            vel[a] <= (m == 0) ? rand_q() : m;
            acc[a] <= (m == 0) ? rand_q() : m;
        end
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) send(1, 0, 1);
            else send(0, 0, 1);
        end
        i_in_valid <= 0;
    endtask

    initial begin
        i_rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        i_in_valid = 0; i_op = 0; done_stim = 0;
        for (int a = 0; a < 3; a++) begin
            meas[a] = 0; vel[a] = 0; acc[a] = 0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);
        // directed: extremes, seed, saturation
        send(0, 32'h7fffffff, 0);
        send(0, 32'h80000000, 0);
        send(1, 32'h00010000, 0);
        send(0, 32'hffffffff, 0);
        send(1, 32'h7fffffff, 0);
        send(0, 32'h80000000, 0);
        send(0, 32'd0, 0);
        i_in_valid <= 0;
        drain();
        write_reg(REG_STEP_TIME, 32'd65536);
        write_reg(REG_PREDICTOR_POLE, 32'h7fffffff);
        write_reg(REG_INPUT_GAIN, 32'h80000000);
        write_reg(REG_SIGMA_LIMIT, 32'h7fffffff);
        write_reg(REG_FILTER_ALPHA, 32'd65536);
        send(0, 32'h7fffffff, 0);
        send(0, 32'h80000000, 0);
        run_phase(10);
        drain();
        write_reg(REG_STEP_TIME, 32'd0);
        write_reg(REG_PREDICTOR_POLE, 32'd0);
        write_reg(REG_INPUT_GAIN, 32'h7fffffff);
        write_reg(REG_SIGMA_LIMIT, 32'd0);
        write_reg(REG_FILTER_ALPHA, 32'd0);
        run_phase(10);
        drain();
        write_reg(REG_FILTER_ALPHA, 32'h1ffff);
        write_reg(REG_SIGMA_LIMIT, 32'd1 << 22);
        write_reg(REG_PREDICTOR_POLE, 32'd1 << 18);
        write_reg(REG_STEP_TIME, 32'd655);
        hold_long = 1;
        run_phase(600);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_STEP_TIME, $urandom_range(0, 65536));
            write_reg(REG_PREDICTOR_POLE, $urandom_range(0, 1 << 22));
            write_reg(REG_INPUT_GAIN, $urandom);
            write_reg(REG_SIGMA_LIMIT, $urandom & 32'h7fffffff);
            write_reg(REG_FILTER_ALPHA, $urandom_range(0, 65536));
            run_phase(340);
            drain();
        end
        done_stim = 1;
    end

    // receiver stalls, with one long hold-off early in the long phase
    initial begin
        int n;
        i_out_stall = 1;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                hold_long = 0;
                i_out_stall <= 1;
                repeat (800) @(negedge i_clk);
            end
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            i_out_stall <= (n != 0);
            repeat (n) @(negedge i_clk);
            i_out_stall <= 0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        idle_cycles = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (done_stim) begin
                if (fail_count == 0) begin
                    $display("Testbench completed without errors");
                end else begin
                    $display("Testbench completed WITH ERRORS");
                end
                $finish;
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 5000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end
endmodule
